/* rtl/core/spa_pkg.sv */
// shared constants, codes and types of the swap page allocator
package spa_pkg;

  localparam int ACTION_W      = 2;
  localparam int COUNT_W       = 13;
  localparam int PAGE_W        = 12;
  localparam int STATUS_W      = 2;
  localparam int MAX_PAGES_DEF = 4096;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [ACTION_W-1:0] ACT_RESERVE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UNRESERVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ALLOC     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FREE      = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR     = 2'd2;

  typedef struct packed {
    logic rd;
    logic wr;
  } map_cmd_t;

endpackage

/* rtl/core/spa_map.sv */
// single-port used-page bitmap memory with registered read data
module spa_map #(
  parameter int WORD_BITS = 32,
  parameter int WORDS     = 128,
  parameter int AW        = 7
) (
  input  logic                 clk,
  input  spa_pkg::map_cmd_t    cmd,
  input  logic [AW-1:0]        addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata
);
  import spa_pkg::*;

  logic [WORD_BITS-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/core/spa_ctrl.sv */
// request sequencer, counters and bitmap search of the swap page allocator
module spa_ctrl #(
  parameter int MAX_PAGES = 4096,
  parameter int WORD_BITS = 32,
  parameter int WORDS     = 128,
  parameter int AW        = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [spa_pkg::ACTION_W-1:0]  action,
  input  logic [spa_pkg::COUNT_W-1:0]   count,
  input  logic [spa_pkg::PAGE_W-1:0]    page_index,
  input  logic                          cfg_we,
  input  logic [spa_pkg::COUNT_W-1:0]   cfg_total,
  output logic                          done,
  output logic [spa_pkg::STATUS_W-1:0]  status,
  output logic [spa_pkg::PAGE_W-1:0]    granted_page,
  output logic [spa_pkg::COUNT_W-1:0]   free_pages,
  output logic [spa_pkg::COUNT_W-1:0]   reserved_pages,
  output spa_pkg::map_cmd_t             map_cmd,
  output logic [AW-1:0]                 map_addr,
  output logic [WORD_BITS-1:0]          map_wdata,
  input  logic [WORD_BITS-1:0]          map_rdata
);
  import spa_pkg::*;

  localparam int PW    = $clog2(MAX_PAGES);
  localparam int TW    = $clog2(MAX_PAGES + 1);
  localparam int BW    = $clog2(WORDS * WORD_BITS + 1);
  localparam int CW    = (TW > COUNT_W) ? TW : COUNT_W;
  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int SH    = PW + 1;
  localparam int RECIP = (1 << SH) / WORD_BITS;
  localparam int PRW   = PW + SH;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FDIV  = 3'd2;
  localparam logic [2:0] S_FMOD  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FWB   = 3'd5;
  localparam logic [2:0] S_ARD   = 3'd6;
  localparam logic [2:0] S_ACHK  = 3'd7;

  logic [2:0]           state;
  logic [AW-1:0]        clr_idx;
  logic [TW-1:0]        total;
  logic [TW-1:0]        free_cnt;
  logic [TW-1:0]        rsv_cnt;
  logic [AW-1:0]        hint;
  logic [BW-1:0]        hint_base;
  logic [AW-1:0]        scan;
  logic [BW-1:0]        scan_base;
  logic [ACTION_W-1:0]  act;
  logic [PW-1:0]        page_in;
  logic [AW-1:0]        qe;
  logic [AW-1:0]        fword;
  logic [BIT_W-1:0]     fbit;

  logic [TW-1:0]        total_clamp;
  logic                 bad;
  logic [TW-1:0]        avail;
  logic [PRW-1:0]       prod;
  logic [BW-1:0]        qprod;
  logic [BW-1:0]        rem0;
  logic [BW-1:0]        rem;
  logic [WORD_BITS-1:0] beyond;
  logic [WORD_BITS-1:0] word_free;
  logic                 found;
  logic [BIT_W-1:0]     fpos;
  logic                 scan_last;
  logic                 fbit_set;

  always_comb begin
    if (cfg_total == '0) begin
      total_clamp = TW'(1);
    end else if (32'(cfg_total) > 32'(MAX_PAGES)) begin
      total_clamp = TW'(MAX_PAGES);
    end else begin
      total_clamp = TW'(cfg_total);
    end
  end

  assign bad   = (free_cnt > total) || (rsv_cnt > free_cnt);
  assign avail = free_cnt - rsv_cnt;

  // word index of a freed page by reciprocal multiply, then one correction step
  assign prod  = PRW'(page_in) * PRW'(RECIP);
  assign qprod = BW'(qe) * BW'(WORD_BITS);
  assign rem0  = BW'(page_in) - qprod;

  // pages at or above the total count as used
  assign rem = BW'(total) - scan_base;
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      beyond[i] = (BW'(i) >= rem);
    end
  end
  assign word_free = ~map_rdata & ~beyond;

  always_comb begin
    found = 1'b0;
    fpos  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_free[i]) begin
        found = 1'b1;
        fpos  = BIT_W'(i);
      end
    end
  end

  assign scan_last = (scan == AW'(WORDS - 1)) ||
                     ((scan_base + BW'(WORD_BITS)) >= BW'(total));
  assign fbit_set  = map_rdata[fbit];

  always_comb begin
    map_cmd   = '0;
    map_addr  = scan;
    map_wdata = map_rdata | (WORD_BITS'(1) << fpos);
    unique case (state)
      S_CLEAR: begin
        map_cmd.wr = 1'b1;
        map_addr   = clr_idx;
        map_wdata  = WORD_BITS'(clr_idx == '0);
      end
      S_FRD: begin
        map_cmd.rd = 1'b1;
        map_addr   = fword;
      end
      S_FWB: begin
        map_cmd.wr = fbit_set;
        map_addr   = fword;
        map_wdata  = map_rdata & ~(WORD_BITS'(1) << fbit);
      end
      S_ARD: begin
        map_cmd.rd = 1'b1;
      end
      S_ACHK: begin
        map_cmd.wr = found;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      total     <= TW'(MAX_PAGES);
      free_cnt  <= TW'(MAX_PAGES - 1);
      rsv_cnt   <= '0;
      hint      <= '0;
      hint_base <= '0;
      done      <= 1'b0;
    end else if (cfg_we) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      total     <= total_clamp;
      free_cnt  <= total_clamp - TW'(1);
      rsv_cnt   <= '0;
      hint      <= '0;
      hint_base <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            act          <= action;
            page_in      <= PW'(page_index);
            granted_page <= '0;
            if (bad) begin
              done   <= 1'b1;
              status <= ST_ERR;
            end else begin
              case (action)
                ACT_RESERVE: begin
                  done <= 1'b1;
                  if (CW'(avail) < CW'(count)) begin
                    status <= ST_NOSPACE;
                  end else begin
                    status  <= ST_OK;
                    rsv_cnt <= rsv_cnt + TW'(count);
                  end
                end
                ACT_UNRESERVE: begin
                  done <= 1'b1;
                  if (CW'(count) > CW'(rsv_cnt)) begin
                    status <= ST_ERR;
                  end else begin
                    status  <= ST_OK;
                    rsv_cnt <= rsv_cnt - TW'(count);
                  end
                end
                ACT_ALLOC: begin
                  if (rsv_cnt == '0 || free_cnt == '0) begin
                    done   <= 1'b1;
                    status <= ST_ERR;
                  end else begin
                    scan      <= hint;
                    scan_base <= hint_base;
                    state     <= S_ARD;
                  end
                end
                default: begin
                  if (page_index == '0 || CW'(page_index) >= CW'(total) ||
                      free_cnt >= total) begin
                    done   <= 1'b1;
                    status <= ST_ERR;
                  end else begin
                    state <= S_FDIV;
                  end
                end
              endcase
            end
          end
        end
        S_FDIV: begin
          qe    <= prod[SH +: AW];
          state <= S_FMOD;
        end
        S_FMOD: begin
          if (rem0 >= BW'(WORD_BITS)) begin
            fword <= qe + AW'(1);
            fbit  <= BIT_W'(rem0 - BW'(WORD_BITS));
          end else begin
            fword <= qe;
            fbit  <= BIT_W'(rem0);
          end
          state <= S_FRD;
        end
        S_FRD: begin
          state <= S_FWB;
        end
        S_FWB: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (!fbit_set) begin
            status <= ST_ERR;
          end else begin
            status   <= ST_OK;
            free_cnt <= free_cnt + TW'(1);
            if (fword < hint) begin
              hint      <= fword;
              hint_base <= BW'(page_in) - BW'(fbit);
            end
          end
        end
        S_ARD: begin
          state <= S_ACHK;
        end
        S_ACHK: begin
          if (found) begin
            done         <= 1'b1;
            status       <= ST_OK;
            granted_page <= PAGE_W'(scan_base + BW'(fpos));
            rsv_cnt      <= rsv_cnt - TW'(1);
            free_cnt     <= free_cnt - TW'(1);
            hint         <= scan;
            hint_base    <= scan_base;
            state        <= S_IDLE;
          end else if (scan_last) begin
            done   <= 1'b1;
            status <= ST_ERR;
            state  <= S_IDLE;
          end else begin
            scan      <= scan + AW'(1);
            scan_base <= scan_base + BW'(WORD_BITS);
            state     <= S_ARD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state != S_IDLE);
  assign free_pages     = COUNT_W'(free_cnt);
  assign reserved_pages = COUNT_W'(rsv_cnt);

  a_no_page_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK && act == ACT_ALLOC) |-> (granted_page != '0))
    else $error("page zero granted");

  a_counters: assert property (@(posedge clk) disable iff (rst)
    (rsv_cnt <= free_cnt) && (free_cnt < total))
    else $error("counter invariant broken");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    map_cmd.wr |-> !map_cmd.rd)
    else $error("map read and write in one cycle");

  a_alloc_result: assert property (@(posedge clk) disable iff (rst || cfg_we)
    (state == S_ACHK && map_cmd.wr) |=> (done && status == ST_OK))
    else $error("claimed page without ok result");

endmodule

/* rtl/core/swap_page_allocator_with_reserve.sv */
// top level of the swap page allocator with reservation
//
// Requests: drive action, count and page_index with start; a transaction is
// taken at a clock edge with start high and busy low. Each transaction gives
// one result on status, granted_page, free_pages and reserved_pages, marked
// by done for a single cycle; the receiver cannot hold results off.
// Result paths, from the accepting edge to the done cycle:
//   reserve, unreserve and requests refused by the counter or range checks: done in the cycle after
//   free: word index by reciprocal multiply and a correction step, bitmap read, write back
//   allocate: a bitmap read and a check per word, starting at the lowest word
//   that may still hold a clear page
// The bitmap sits in one single-port memory; that port and the word-by-word
// search set the rate. busy stays high until the result is issued.
// Reset or a write to total_pages (total_pages_we) restarts the counters and
// runs a clearing pass over the bitmap, one word a cycle, through all
// MAX_PAGES / MAP_WORD_BITS words (rounded up, 128 at the defaults), with busy high.
module swap_page_allocator_with_reserve #(
  parameter int MAX_PAGES     = spa_pkg::MAX_PAGES_DEF,
  parameter int MAP_WORD_BITS = spa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [spa_pkg::ACTION_W-1:0]  action,
  input  logic [spa_pkg::COUNT_W-1:0]   count,
  input  logic [spa_pkg::PAGE_W-1:0]    page_index,
  input  logic                          total_pages_we,
  input  logic [spa_pkg::COUNT_W-1:0]   total_pages,
  output logic                          done,
  output logic [spa_pkg::STATUS_W-1:0]  status,
  output logic [spa_pkg::PAGE_W-1:0]    granted_page,
  output logic [spa_pkg::COUNT_W-1:0]   free_pages,
  output logic [spa_pkg::COUNT_W-1:0]   reserved_pages
);
  import spa_pkg::*;

  localparam int WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  map_cmd_t                 map_cmd;
  logic [AW-1:0]            map_addr;
  logic [MAP_WORD_BITS-1:0] map_wdata;
  logic [MAP_WORD_BITS-1:0] map_rdata;

  spa_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (MAP_WORD_BITS),
    .WORDS     (WORDS),
    .AW        (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .count          (count),
    .page_index     (page_index),
    .cfg_we         (total_pages_we),
    .cfg_total      (total_pages),
    .done           (done),
    .status         (status),
    .granted_page   (granted_page),
    .free_pages     (free_pages),
    .reserved_pages (reserved_pages),
    .map_cmd        (map_cmd),
    .map_addr       (map_addr),
    .map_wdata      (map_wdata),
    .map_rdata      (map_rdata)
  );

  spa_map #(
    .WORD_BITS (MAP_WORD_BITS),
    .WORDS     (WORDS),
    .AW        (AW)
  ) u_map (
    .clk   (clk),
    .cmd   (map_cmd),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

endmodule

/* tb/tb.sv */
// self-checking testbench for the swap page allocator with reservation
module tb;
  import spa_pkg::*;

  localparam int MAX_PAGES   = MAX_PAGES_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 32;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    bit                  is_cfg;
    logic [COUNT_W-1:0]  cfg_val;
    logic [ACTION_W-1:0] act;
    logic [COUNT_W-1:0]  cnt;
    logic [PAGE_W-1:0]   pg;
    int                  idle_pct;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page;
    logic [COUNT_W-1:0]  free_n;
    logic [COUNT_W-1:0]  rsv_n;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [ACTION_W-1:0] action = '0;
  logic [COUNT_W-1:0]  count = '0;
  logic [PAGE_W-1:0]   page_index = '0;
  logic                total_pages_we = 1'b0;
  logic [COUNT_W-1:0]  total_pages = '0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   granted_page;
  logic [COUNT_W-1:0]  free_pages;
  logic [COUNT_W-1:0]  reserved_pages;

  swap_page_allocator_with_reserve u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .count          (count),
    .page_index     (page_index),
    .total_pages_we (total_pages_we),
    .total_pages    (total_pages),
    .done           (done),
    .status         (status),
    .granted_page   (granted_page),
    .free_pages     (free_pages),
    .reserved_pages (reserved_pages)
  );

  always #1 clk = ~clk;

  request_t    request_queue[$];
  outcome_t    pending_outcomes[$];
  int          errors = 0;
  int          accepted = 0;
  int          cfg_writes = 0;
  int          tally[4] = '{0, 0, 0, 0};
  logic        took = 1'b0;

  // shadow of the allocator state
  bit [MAX_PAGES-1:0] shadow_used;
  int unsigned        shadow_free;
  int unsigned        shadow_rsv;
  int unsigned        shadow_total;

  // generator bookkeeping
  int gen_idle = 0;
  int gen_items = 0;
  int gen_total = MAX_PAGES;
  int gen_est = 0;

  task automatic report(string msg);
    if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void restart_shadow(int unsigned t);
    if (t < 1) t = 1;
    if (t > MAX_PAGES) t = MAX_PAGES;
    shadow_total = t;
    shadow_used = '0;
    shadow_used[0] = 1'b1;
    shadow_free = t - 1;
    shadow_rsv = 0;
  endfunction

  function automatic outcome_t allocator_step(logic [ACTION_W-1:0] a, logic [COUNT_W-1:0] c,
                                              logic [PAGE_W-1:0] pg);
    outcome_t o;
    bit found;
    int unsigned grant;
    o.status = ST_OK;
    grant = 0;
    found = 1'b0;
    if (shadow_free > shadow_total || shadow_rsv > shadow_free) begin
      o.status = ST_ERR;
    end else begin
      case (a)
        ACT_RESERVE: begin
          if (shadow_free - shadow_rsv < c) o.status = ST_NOSPACE;
          else shadow_rsv += c;
        end
        ACT_UNRESERVE: begin
          if (c > shadow_rsv) o.status = ST_ERR;
          else shadow_rsv -= c;
        end
        ACT_ALLOC: begin
          if (shadow_rsv == 0 || shadow_free == 0) begin
            o.status = ST_ERR;
          end else begin
            for (int p = 0; p < shadow_total && !found; p++) begin
              if (!shadow_used[p]) begin
                found = 1'b1;
                grant = p;
              end
            end
            if (!found) begin
              o.status = ST_ERR;
            end else begin
              shadow_used[grant] = 1'b1;
              shadow_rsv--;
              shadow_free--;
            end
          end
        end
        ACT_FREE: begin
          if (pg == 0 || pg >= shadow_total || shadow_free >= shadow_total ||
              !shadow_used[pg]) begin
            o.status = ST_ERR;
          end else begin
            shadow_used[pg] = 1'b0;
            shadow_free++;
          end
        end
      endcase
    end
    if (o.status != ST_OK) grant = 0;
    o.page = grant[PAGE_W-1:0];
    o.free_n = shadow_free[COUNT_W-1:0];
    o.rsv_n = shadow_rsv[COUNT_W-1:0];
    return o;
  endfunction

  task automatic queue_req(logic [ACTION_W-1:0] a, int unsigned c, int unsigned p);
    request_t r;
    r.is_cfg = 1'b0;
    r.cfg_val = '0;
    r.act = a;
    r.cnt = c[COUNT_W-1:0];
    r.pg = p[PAGE_W-1:0];
    r.idle_pct = gen_idle;
    request_queue.push_back(r);
    gen_items++;
  endtask

  task automatic queue_cfg(int unsigned v);
    request_t r;
    r.is_cfg = 1'b1;
    r.cfg_val = v[COUNT_W-1:0];
    r.act = ACT_RESERVE;
    r.cnt = '0;
    r.pg = '0;
    r.idle_pct = gen_idle;
    request_queue.push_back(r);
    gen_total = (r.cfg_val == 0) ? 1 : (r.cfg_val > MAX_PAGES) ? MAX_PAGES : r.cfg_val;
    gen_est = 0;
  endtask

  // mostly reserve/allocate/free sequences, the rest random noise
  task automatic queue_traffic(int n);
    int target;
    int r;
    int k;
    int hi;
    target = gen_items + n;
    while (gen_items < target) begin
      if ($urandom_range(0, 99) < 70) begin
        r = $urandom_range(1, 6);
        queue_req(ACT_RESERVE, r, $urandom);
        k = r + (($urandom_range(0, 9) == 0) ? 1 : 0);
        repeat (k) begin
          queue_req(ACT_ALLOC, $urandom, $urandom);
          gen_est++;
        end
        repeat ($urandom_range(0, r)) begin
          hi = gen_est + 2;
          if (hi > gen_total) hi = gen_total;
          if (hi > 4095) hi = 4095;
          queue_req(ACT_FREE, $urandom, $urandom_range(1, hi));
          if (gen_est > 0) gen_est--;
        end
        if ($urandom_range(0, 4) == 0) queue_req(ACT_UNRESERVE, $urandom_range(0, 3), $urandom);
      end else begin
        hi = gen_est + 2;
        if (hi > 4095) hi = 4095;
        queue_req(ACTION_W'($urandom),
                  $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(0, 8),
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, hi));
      end
    end
  endtask

  // driver: one decision per falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      total_pages_we <= 1'b0;
    end else if (total_pages_we) begin
      total_pages_we <= 1'b0;
    end else if (!(start && !took)) begin
      if (request_queue.size() == 0) begin
        start <= 1'b0;
      end else if (request_queue[0].is_cfg) begin
        start <= 1'b0;
        if (pending_outcomes.size() == 0 && !busy) begin
          total_pages <= request_queue[0].cfg_val;
          total_pages_we <= 1'b1;
          void'(request_queue.pop_front());
        end
      end else if ($urandom_range(0, 99) < request_queue[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        action <= request_queue[0].act;
        count <= request_queue[0].cnt;
        page_index <= request_queue[0].pg;
        start <= 1'b1;
        void'(request_queue.pop_front());
      end
    end
  end

  // monitor and prediction at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      restart_shadow(MAX_PAGES);
      took <= 1'b0;
    end else begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          report("result with no transaction outstanding");
        end else begin
          if (status !== pending_outcomes[0].status)
            report($sformatf("status got %0d want %0d", status, pending_outcomes[0].status));
          if (granted_page !== pending_outcomes[0].page)
            report($sformatf("granted_page got %0d want %0d", granted_page,
                             pending_outcomes[0].page));
          if (free_pages !== pending_outcomes[0].free_n)
            report($sformatf("free_pages got %0d want %0d", free_pages,
                             pending_outcomes[0].free_n));
          if (reserved_pages !== pending_outcomes[0].rsv_n)
            report($sformatf("reserved_pages got %0d want %0d", reserved_pages,
                             pending_outcomes[0].rsv_n));
          tally[pending_outcomes[0].status]++;
          void'(pending_outcomes.pop_front());
        end
      end
      if (total_pages_we) begin
        restart_shadow(total_pages);
        cfg_writes++;
      end
      took <= start && !busy;
      if (start && !busy) begin
        pending_outcomes.push_back(allocator_step(action, count, page_index));
        accepted++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    // directed part, first on the reset total, then after writes of total_pages
    queue_req(ACT_ALLOC, 0, 0);
    queue_req(ACT_FREE, 0, 0);
    queue_req(ACT_FREE, 0, 4095);
    queue_req(ACT_UNRESERVE, 1, 0);
    queue_req(ACT_RESERVE, 8191, 4095);
    queue_req(ACT_RESERVE, 4095, 0);
    queue_req(ACT_RESERVE, 1, 0);
    queue_req(ACT_UNRESERVE, 4092, 0);
    queue_req(ACT_ALLOC, 0, 0);
    queue_req(ACT_ALLOC, 0, 0);
    queue_req(ACT_ALLOC, 0, 0);
    queue_req(ACT_FREE, 0, 2);
    queue_req(ACT_RESERVE, 0, 0);
    queue_req(ACT_RESERVE, 1, 0);
    queue_req(ACT_ALLOC, 0, 0);
    queue_cfg(1);
    queue_req(ACT_RESERVE, 1, 0);
    queue_req(ACT_ALLOC, 0, 0);
    queue_req(ACT_FREE, 0, 1);
    queue_cfg(0);
    queue_req(ACT_FREE, 0, 0);
    queue_cfg(8191);
    queue_req(ACT_RESERVE, 4095, 0);
    queue_req(ACT_ALLOC, 8191, 4095);
    queue_cfg(3);
    queue_req(ACT_RESERVE, 2, 0);
    queue_req(ACT_ALLOC, 0, 0);
    queue_req(ACT_ALLOC, 0, 0);
    queue_req(ACT_ALLOC, 0, 0);
    queue_req(ACT_FREE, 0, 3);

    // random phases with different totals and sender idling
    gen_idle = 0;
    queue_cfg(37);
    queue_traffic(220);
    gen_idle = 47;
    queue_cfg(4096);
    queue_traffic(220);
    gen_idle = 0;
    queue_cfg($urandom_range(2, 300));
    queue_traffic(220);
    gen_idle = 27;
    queue_cfg(5);
    queue_traffic(220);
    gen_idle = 47;
    queue_cfg($urandom_range(1, 4096));
    queue_traffic(220);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (!(request_queue.size() == 0 && !start && !total_pages_we &&
             pending_outcomes.size() == 0));
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) report("transactions left without a result");

    $display("covered %0d transactions over %0d writes of total_pages", accepted, cfg_writes);
    $display("outcomes: ok %0d, no space %0d, rejected %0d", tally[ST_OK], tally[ST_NOSPACE],
             tally[ST_ERR]);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
